/* design/crst_pkg.sv */
// Package for the character range set table unit.
// Types, constants and action codes used by the cell and the top level.
package crst_pkg;
   localparam int MaxRanges = 16;
   localparam int CharBits = 16;
   localparam int IdxBits = $clog2(MaxRanges);
   localparam int CntBits = $clog2(MaxRanges + 1);
   localparam int LimBits = CharBits + 1;
   localparam logic [15:0] TotalMax = 16'hffff;

   typedef logic [CharBits-1:0] char_type;

   typedef enum logic [2:0] {
      ACT_CLEAR = 3'd0, ACT_ADD = 3'd1, ACT_DELETE = 3'd2, ACT_TEST_CHAR = 3'd3,
      ACT_TEST_RANGE = 3'd4, ACT_COMPLEMENT = 3'd5, ACT_READ_SLOT = 3'd6,
      ACT_NONE = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_TAIL, ST_CHECK, ST_COMMIT, ST_SUM, ST_DONE
   } state_type;

   // one stored range as it travels down the chain
   typedef struct packed {
      logic     valid;
      char_type first;
      char_type last;
   } range_type;

   // control from the sequencer to every cell
   typedef struct packed {
      logic shift;    // rotate stored row by one position
      logic clear;    // drop all entries
   } cell_ctl_type;
endpackage

/* design/character_range_set_table_unit.sv */
// Top level of the character range set table unit: sequencer and cell chain.
// Depends on crst_pkg and crst_cell.
//
//  port group | dir | transfer when
//  req_*      | in  | req_valid  & !req_stall
//  rsp_*      | out | rsp_valid  & !rsp_stall
//  csr_*      | in  | csr_valid  & csr_ready
//
// One item at a time. The chain rotates through all slots to scan the table,
// then, when the table changes and the result fits, the staging queue is
// loaded into it, then the chain rotates through all slots again to sum the
// character count. Reset empties the table.
// rsp holds while stalled; a new item is taken once the result is taken.
// csr is taken only while idle with no req offered.
module character_range_set_table_unit
   import crst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_range_low,
   input  logic [15:0] req_range_high,
   input  logic [3:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_status,
   output logic [4:0]  rsp_range_total,
   output logic [15:0] rsp_char_total,
   output logic [15:0] rsp_read_first,
   output logic [15:0] rsp_read_last,
   output logic        rsp_read_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   localparam int QDepth = MaxRanges + 2;
   localparam int QBits = $clog2(QDepth + 2);

   state_type state_ff, state_in;
   logic [15:0] limit_ff;
   action_type act_ff;
   char_type lo_ff, hi_ff;
   logic [3:0] slot_ff;
   logic [IdxBits:0] step_ff, step_in;
   logic [CntBits-1:0] used_ff;
   logic [CntBits-1:0] seen_ff;

   // work state
   char_type b_ff, e_ff;         // add: pending merged range
   logic phase_ff;               // add: 0 before merge, 1 merging/placed
   logic done_ff;                // add: merged range pushed; complement: stopped
   logic [LimBits-1:0] next_ff;  // complement cursor
   logic hit_ff, status_ff, rvalid_ff, nop_ff;
   char_type rf_ff, rl_ff;
   logic [16:0] total_ff;

   // staging queue
   range_type q_ff [QDepth];
   logic [QBits-1:0] qcnt_ff;

   cell_ctl_type ctl;
   range_type cell_out [MaxRanges];
   range_type chain_in;

   genvar g;
   generate
      for (g = 0; g < MaxRanges; g++) begin : g_cell
         range_type prev;
         if (g == 0) begin : g_first
            assign prev = chain_in;
         end else begin : g_link
            assign prev = cell_out[g-1];
         end
         crst_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .from_prev(prev),
            .held(cell_out[g])
         );
      end
   endgenerate

   range_type head;
   assign head = cell_out[MaxRanges-1];

   logic [LimBits-1:0] lim;
   assign lim = ({1'b0, limit_ff} < (LimBits'(1) << CharBits)) ?
                LimBits'(limit_ff) : (LimBits'(1) << CharBits);

   logic [LimBits-1:0] s_x, t_x, b_x, e_x;
   assign s_x = LimBits'(head.first);
   assign t_x = LimBits'(head.last);
   assign b_x = LimBits'(b_ff);
   assign e_x = LimBits'(e_ff);
   logic live;
   assign live = head.valid && (LimBits'(seen_ff) < LimBits'(used_ff));

   // add ends of the offered item, ordered, with the upper end clamped below the limit
   logic [LimBits-1:0] req_b_x, req_e_x, req_e_cl;
   assign req_b_x = LimBits'((req_range_high < req_range_low) ? req_range_high : req_range_low);
   assign req_e_x = LimBits'((req_range_high < req_range_low) ? req_range_low : req_range_high);
   assign req_e_cl = (req_e_x >= lim) ? lim - 1'b1 : req_e_x;

   // push requests for one scan or tail step
   logic p0, p1;
   range_type r0, r1;

   always_comb begin
      p0 = 1'b0; p1 = 1'b0;
      r0 = '0; r1 = '0;
      if (state_ff == ST_SCAN && live) begin
         case (act_ff)
            ACT_ADD: begin
               if (!phase_ff && t_x + 1 < b_x) begin
                  p0 = 1'b1; r0 = head;
               end else if (!done_ff && s_x <= e_x + 1) begin
               end else if (!done_ff) begin
                  p0 = 1'b1; r0 = '{1'b1, b_ff, e_ff};
                  p1 = 1'b1; r1 = head;
               end else begin
                  p0 = 1'b1; r0 = head;
               end
            end
            ACT_DELETE: begin
               if (head.last < lo_ff || head.first > hi_ff) begin
                  p0 = 1'b1; r0 = head;
               end else begin
                  if (head.first < lo_ff) begin
                     p0 = 1'b1; r0 = '{1'b1, head.first, lo_ff - 1'b1};
                  end
                  if (head.last > hi_ff) begin
                     p1 = 1'b1; r1 = '{1'b1, hi_ff + 1'b1, head.last};
                  end
               end
            end
            ACT_COMPLEMENT: begin
               if (!done_ff && s_x < lim && s_x > next_ff) begin
                  p0 = 1'b1;
                  r0 = '{1'b1, CharBits'(next_ff), head.first - 1'b1};
               end
            end
            default: ;
         endcase
      end else if (state_ff == ST_TAIL) begin
         case (act_ff)
            ACT_ADD: begin
               if (!done_ff) begin
                  p0 = 1'b1; r0 = '{1'b1, b_ff, e_ff};
               end
            end
            ACT_COMPLEMENT: begin
               if (next_ff < lim) begin
                  p0 = 1'b1; r0 = '{1'b1, CharBits'(next_ff), CharBits'(lim - 1'b1)};
               end
            end
            default: ;
         endcase
      end
   end

   // sequencer next state
   logic last_step;
   assign last_step = (step_ff == (IdxBits+1)'(MaxRanges - 1));
   logic changes;
   assign changes = (act_ff == ACT_ADD || act_ff == ACT_DELETE ||
                     act_ff == ACT_COMPLEMENT) && !nop_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = ST_SCAN; step_in = '0;
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (last_step) state_in = ST_TAIL;
         end
         ST_TAIL: state_in = ST_CHECK;
         ST_CHECK: begin
            step_in = '0;
            if (changes && qcnt_ff <= QBits'(MaxRanges)) state_in = ST_COMMIT;
            else state_in = ST_SUM;
         end
         ST_COMMIT: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_SUM; step_in = '0;
            end
         end
         ST_SUM: begin
            step_in = step_ff + 1'b1;
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // cell chain control
   always_comb begin
      ctl.shift = 1'b0;
      ctl.clear = 1'b0;
      chain_in = head;
      case (state_ff)
         ST_SCAN, ST_SUM: ctl.shift = 1'b1;
         ST_CHECK: ctl.clear = (changes && qcnt_ff <= QBits'(MaxRanges)) ||
                               (act_ff == ACT_CLEAR);
         ST_COMMIT: begin
            ctl.shift = 1'b1;
            chain_in = q_ff[0];
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= 16'hffff;
         used_ff <= '0;
         qcnt_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         if (csr_valid && csr_ready) limit_ff <= csr_data;
         if (state_ff == ST_IDLE) qcnt_ff <= '0;
         else if (state_ff == ST_COMMIT) qcnt_ff <= qcnt_ff;
         else if (p0 && p1) qcnt_ff <= qcnt_ff + 2'd2;
         else if (p0 || p1) qcnt_ff <= qcnt_ff + 1'b1;
         if (state_ff == ST_CHECK) begin
            if (act_ff == ACT_CLEAR) used_ff <= '0;
            else if (changes && qcnt_ff <= QBits'(MaxRanges))
               used_ff <= CntBits'(qcnt_ff);
         end
      end
   end

   // staging queue: appended during scan and tail, shifted out during commit, cleared while idle
   always_ff @(posedge clock) begin
      if (state_ff == ST_COMMIT) begin
         for (int k = 0; k < QDepth - 1; k++) q_ff[k] <= q_ff[k+1];
         q_ff[QDepth-1] <= '0;
      end else if (state_ff == ST_IDLE) begin
         for (int k = 0; k < QDepth; k++) q_ff[k] <= '0;
      end else begin
         for (int k = 0; k < QDepth; k++) begin
            if (p0 && QBits'(k) == qcnt_ff) q_ff[k] <= r0;
            if (p1 && QBits'(k) == qcnt_ff + (p0 ? QBits'(1) : QBits'(0)))
               q_ff[k] <= r1;
         end
      end
   end

   // item capture and per-step work
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            act_ff <= action_type'(req_action);
            slot_ff <= req_slot;
            if ((req_action == ACT_ADD || req_action == ACT_DELETE ||
                 req_action == ACT_TEST_RANGE) && req_range_high < req_range_low) begin
               lo_ff <= req_range_high; hi_ff <= req_range_low;
            end else begin
               lo_ff <= req_range_low; hi_ff <= req_range_high;
            end
            b_ff <= CharBits'(req_b_x);
            e_ff <= CharBits'(req_e_cl);
            phase_ff <= 1'b0; done_ff <= 1'b0;
            next_ff <= '0;
            seen_ff <= '0;
            hit_ff <= 1'b0; rvalid_ff <= 1'b0; rf_ff <= '0; rl_ff <= '0;
            total_ff <= '0;
            nop_ff <= (req_action == ACT_ADD) && (lim == '0 || req_b_x > req_e_cl);
         end
         ST_SCAN: begin
            seen_ff <= seen_ff + 1'b1;
            if (live) begin
               case (act_ff)
                  ACT_ADD: begin
                     if (!phase_ff && t_x + 1 < b_x) begin
                     end else if (!done_ff && s_x <= e_x + 1) begin
                        phase_ff <= 1'b1;
                        if (head.first < b_ff) b_ff <= head.first;
                        if (head.last > e_ff) e_ff <= head.last;
                     end else begin
                        phase_ff <= 1'b1; done_ff <= 1'b1;
                     end
                  end
                  ACT_TEST_CHAR:
                     if (head.first <= lo_ff && lo_ff <= head.last) hit_ff <= 1'b1;
                  ACT_TEST_RANGE:
                     if (head.first <= lo_ff && hi_ff <= head.last) hit_ff <= 1'b1;
                  ACT_COMPLEMENT: begin
                     if (!done_ff) begin
                        if (s_x >= lim) done_ff <= 1'b1;
                        else next_ff <= t_x + 1'b1;
                     end
                  end
                  ACT_READ_SLOT:
                     if (IdxBits'(seen_ff) == slot_ff && seen_ff < CntBits'(MaxRanges)) begin
                        rvalid_ff <= 1'b1; rf_ff <= head.first; rl_ff <= head.last;
                     end
                  default: ;
               endcase
            end
         end
         ST_TAIL: ;
         ST_CHECK: begin
            status_ff <= changes && qcnt_ff > QBits'(MaxRanges);
            if (act_ff == ACT_TEST_CHAR || act_ff == ACT_TEST_RANGE) ;
            else hit_ff <= 1'b0;
            seen_ff <= '0;
         end
         ST_SUM: begin
            seen_ff <= seen_ff + 1'b1;
            if (head.valid && LimBits'(seen_ff) < LimBits'(used_ff)) begin
               if (total_ff + 17'(head.last) - 17'(head.first) + 17'd1 > 17'(TotalMax))
                  total_ff <= 17'(TotalMax);
               else
                  total_ff <= total_ff + 17'(head.last) - 17'(head.first) + 17'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_hit = hit_ff;
   assign rsp_status = status_ff;
   assign rsp_range_total = 5'(used_ff);
   assign rsp_char_total = total_ff[15:0];
   assign rsp_read_first = rf_ff;
   assign rsp_read_last = rl_ff;
   assign rsp_read_valid = rvalid_ff;
endmodule

/* design/crst_cell.sv */
// One slot of the range chain: holds a range and hands it to its neighbor.
// Depends on crst_pkg.
module crst_cell
   import crst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  range_type    from_prev,
   output range_type    held
);
   range_type held_ff, held_in;

   always_comb begin
      held_in = held_ff;
      if (ctl.clear) begin
         held_in.valid = 1'b0;
      end else if (ctl.shift) begin
         held_in = from_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
      end
      held_ff.first <= held_in.first;
      held_ff.last  <= held_in.last;
   end

   assign held = held_ff;
endmodule
